// ----- src/gradient_cluster_merge_defines.svh -----
// assertion helpers shared by the block
`ifndef GRADIENT_CLUSTER_MERGE_DEFINES_SVH
`define GRADIENT_CLUSTER_MERGE_DEFINES_SVH

// condition holds in the same cycle
`define GCM_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// condition holds in the next cycle
`define GCM_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/gcm_pkg.sv -----
`default_nettype none
package gcm_pkg;

    localparam int PIXEL_COUNT_DEF = 65536;
    localparam int PIX_W   = 16;
    localparam int CNT_W   = 17;
    localparam int ANG_W   = 17;
    localparam int MAG_W   = 16;
    localparam int THR_W   = 24;
    localparam int SUM_W   = CNT_W + 1;
    localparam int TWO_PI  = 51472;
    localparam int PI_Q    = 25736;
    localparam int ANG_MIN = -65536;
    localparam int ANG_MAX = 65535;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    localparam logic [THR_W-1:0] ANG_THR_RST = 24'd819200;
    localparam logic [THR_W-1:0] MAG_THR_RST = 24'd1200;

    // configuration register indexes
    localparam logic CFG_ANGLE_THR = 1'b0;
    localparam logic CFG_MAG_THR   = 1'b1;

    // request kinds
    localparam logic [1:0] REQ_LOAD  = 2'd0;
    localparam logic [1:0] REQ_MERGE = 2'd1;
    localparam logic [1:0] REQ_QUERY = 2'd2;
    localparam logic [1:0] REQ_ALT   = 2'd3;

    // per-pixel set record, parent link kept beside it
    typedef struct packed {
        logic        [CNT_W-1:0] count;
        logic signed [ANG_W-1:0] alow;
        logic signed [ANG_W-1:0] ahigh;
        logic        [MAG_W-1:0] mlow;
        logic        [MAG_W-1:0] mhigh;
    } entry_t;

    // divider status
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage
`default_nettype wire

// ----- src/gcm_store.sv -----
`default_nettype none
module gcm_store #(
    parameter int PIXEL_COUNT = gcm_pkg::PIXEL_COUNT_DEF,
    parameter int IW          = $clog2(PIXEL_COUNT)
) (
    input  wire logic            aclk,
    input  wire logic            rd_en,
    input  wire logic [IW-1:0]   rd_addr,
    output logic      [IW-1:0]   rd_parent,
    output gcm_pkg::entry_t      rd_data,
    input  wire logic            wr_en,
    input  wire logic [IW-1:0]   wr_addr,
    input  wire logic [IW-1:0]   wr_parent,
    input  wire gcm_pkg::entry_t wr_data
);
    localparam int EW = IW + $bits(gcm_pkg::entry_t);

    logic [EW-1:0] mem [0:PIXEL_COUNT-1];
    logic [EW-1:0] rd_q_reg;

    // single write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= {wr_parent, wr_data};
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_q_reg <= mem[rd_addr];
        end
    end

    assign rd_parent = rd_q_reg[EW-1 -: IW];
    assign rd_data   = gcm_pkg::entry_t'(rd_q_reg[$bits(gcm_pkg::entry_t)-1:0]);

endmodule
`default_nettype wire

// ----- src/gcm_div.sv -----
`default_nettype none
module gcm_div (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic [gcm_pkg::THR_W-1:0]   dividend,
    input  wire logic [gcm_pkg::SUM_W-1:0]   divisor,
    output logic      [gcm_pkg::THR_W-1:0]   quotient,
    output gcm_pkg::div_stat_t               stat
);
    localparam int DW = gcm_pkg::THR_W;
    localparam int VW = gcm_pkg::SUM_W;
    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0] quo_reg;
    logic [VW-1:0] rem_reg;
    logic [VW-1:0] den_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [VW:0]   rem_sh;
    logic          fits;

    // one restoring step per cycle
    assign rem_sh = {rem_reg, quo_reg[DW-1]};
    assign fits   = rem_sh >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CW'(DW);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // payload, zero divisor counts as one
    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            den_reg <= (divisor == '0) ? VW'(1) : divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[DW-2:0], fits};
            rem_reg <= fits ? VW'(rem_sh - {1'b0, den_reg}) : rem_sh[VW-1:0];
        end
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule
`default_nettype wire

// ----- src/gradient_cluster_merge.sv -----
// channel   dir  fields (lowest bit up)
// s_        in   tuser: req_type; tdata: pixel_a, pixel_b, angle, magnitude
// m_        out  tdata: root_id, set_count, did_merge, already_joined
// cfg_      in   index 0 angle_threshold, index 1 magnitude_threshold
// index wrap: indexes reduced modulo PIXEL_COUNT by restoring steps when PIXEL_COUNT is below 65536, else none
// load: dispatch, one record write, output; query: a read and a check per link walked to the root
// merge: a read and a check per link walked on both sides, then, unless both roots agree, the
//   bit-serial threshold dividers (24 steps) and, when the thresholds pass, two record writes
// one item at a time through the record memory; no clearing pass
// a finished result waits in the output register while the next beat is taken
`default_nettype none
`include "gradient_cluster_merge_defines.svh"
module gradient_cluster_merge #(
    parameter int PIXEL_COUNT = gcm_pkg::PIXEL_COUNT_DEF
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [63:0]                s_tdata,  // pixel_a, pixel_b, angle, magnitude
    input  wire logic [1:0]                 s_tuser,  // req_type
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic [39:0]                     m_tdata,  // root_id, set_count, did_merge,
                                                      // already_joined, zero fill
    input  wire logic                       cfg_wr_en,
    input  wire logic                       cfg_wr_index,
    input  wire logic [gcm_pkg::THR_W-1:0]  cfg_wr_data
);
    localparam int IW    = $clog2(PIXEL_COUNT);
    localparam bit NWRAP = PIXEL_COUNT < 65536;
    localparam int CNT_W = gcm_pkg::CNT_W;
    localparam int SUM_W = gcm_pkg::SUM_W;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_WRAP    = 4'd1;
    localparam logic [3:0] S_DISP    = 4'd2;
    localparam logic [3:0] S_FA_RD   = 4'd3;
    localparam logic [3:0] S_FA_CHK  = 4'd4;
    localparam logic [3:0] S_FB_RD   = 4'd5;
    localparam logic [3:0] S_FB_CHK  = 4'd6;
    localparam logic [3:0] S_ALIGN   = 4'd7;
    localparam logic [3:0] S_SPAN    = 4'd8;
    localparam logic [3:0] S_DIVW    = 4'd9;
    localparam logic [3:0] S_DECIDE  = 4'd10;
    localparam logic [3:0] S_WR_GONE = 4'd11;
    localparam logic [3:0] S_WR_KEEP = 4'd12;
    localparam logic [3:0] S_OUT     = 4'd13;
    localparam logic [3:0] S_LOAD    = 4'd14;

    logic [3:0] state_reg, state_next;

    logic [gcm_pkg::THR_W-1:0] athr_reg, mthr_reg;

    logic [1:0]  req_reg;
    logic [15:0] pa_w_reg, pb_w_reg;
    logic [15:0] ang_reg, mag_reg;
    logic [3:0]  wcnt_reg;
    logic [IW-1:0] cur_a_reg, cur_b_reg, r0_reg, r1_reg;
    gcm_pkg::entry_t ent_a_reg, ent_b_reg;

    logic signed [20:0] shift_reg;
    logic [15:0]        ml01_reg, mh01_reg;
    logic [SUM_W-1:0]   sz01_reg;
    logic signed [21:0] tl01_reg, th01_reg;
    logic signed [21:0] ang_cost_reg;
    logic signed [17:0] ang_old_reg;
    logic signed [17:0] mag_cost_reg, mag_old_reg;

    logic [IW-1:0]      keep_reg, gone_reg;
    gcm_pkg::entry_t    gone_ent_reg, new_ent_reg;

    logic [IW-1:0]      res_root_reg;
    logic [CNT_W-1:0]   res_count_reg;
    logic               res_merge_reg, res_joined_reg;
    logic               m_tvalid_reg;
    logic [39:0]        m_tdata_reg;

    // store port
    logic            rd_en, wr_en;
    logic [IW-1:0]   rd_addr, rd_parent, wr_addr, wr_parent;
    gcm_pkg::entry_t rd_data, wr_data, load_ent;

    // dividers
    logic                       div_start;
    logic [gcm_pkg::THR_W-1:0]  qa, qm;
    gcm_pkg::div_stat_t         da_stat, dm_stat;

    logic s_acc, out_free;
    assign s_acc    = s_tvalid && s_tready;
    assign s_tready = state_reg == S_IDLE;
    assign out_free = !m_tvalid_reg || m_tready;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            athr_reg <= gcm_pkg::ANG_THR_RST;
            mthr_reg <= gcm_pkg::MAG_THR_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                gcm_pkg::CFG_ANGLE_THR: athr_reg <= cfg_wr_data;
                gcm_pkg::CFG_MAG_THR:   mthr_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // index wrap, one restoring step per cycle
    logic [31:0] wrap_cmp;
    assign wrap_cmp = 32'(PIXEL_COUNT) << wcnt_reg;

    // alignment of the second span
    logic signed [17:0] s0, s1, s0r, s1r, d;
    logic signed [16:0] mean0, mean1;
    logic [17:0]        ad;
    logic [18:0]        xq;
    logic [2:0]         q;
    logic [19:0]        shift_mag;
    always_comb begin
        s0    = 18'(ent_a_reg.alow) + 18'(ent_a_reg.ahigh);
        s1    = 18'(ent_b_reg.alow) + 18'(ent_b_reg.ahigh);
        s0r   = s0 + $signed({17'd0, s0[17]});
        s1r   = s1 + $signed({17'd0, s1[17]});
        mean0 = s0r[17:1];
        mean1 = s1r[17:1];
        d     = 18'(mean1) - 18'(mean0);
        ad    = d[17] ? 18'(-d) : 18'(d);
        xq    = 19'(ad) + 19'(gcm_pkg::PI_Q);
        q     = 3'd0;
        if (xq >= 19'(5 * gcm_pkg::TWO_PI))      q = 3'd5;
        else if (xq >= 19'(4 * gcm_pkg::TWO_PI)) q = 3'd4;
        else if (xq >= 19'(3 * gcm_pkg::TWO_PI)) q = 3'd3;
        else if (xq >= 19'(2 * gcm_pkg::TWO_PI)) q = 3'd2;
        else if (xq >= 19'(gcm_pkg::TWO_PI))     q = 3'd1;
        shift_mag = 20'(q) * 20'(gcm_pkg::TWO_PI);
    end

    // widened spans and their costs
    logic signed [21:0] tl0x, th0x, tl1s, th1s, tl01, th01, span;
    logic signed [17:0] sp0, sp1;
    logic signed [17:0] mc0, mc1;
    always_comb begin
        tl0x = 22'(ent_a_reg.alow);
        th0x = 22'(ent_a_reg.ahigh);
        tl1s = 22'(ent_b_reg.alow) + 22'(shift_reg);
        th1s = 22'(ent_b_reg.ahigh) + 22'(shift_reg);
        tl01 = (tl1s < tl0x) ? tl1s : tl0x;
        th01 = (th1s > th0x) ? th1s : th0x;
        span = th01 - tl01;
        if (span > 22'(gcm_pkg::TWO_PI)) begin
            th01 = tl01 + 22'(gcm_pkg::TWO_PI);
        end
        sp0 = 18'(ent_a_reg.ahigh) - 18'(ent_a_reg.alow);
        sp1 = 18'(ent_b_reg.ahigh) - 18'(ent_b_reg.alow);
        mc0 = $signed({2'b00, ent_a_reg.mhigh}) - $signed({2'b00, ent_a_reg.mlow});
        mc1 = $signed({2'b00, ent_b_reg.mhigh}) - $signed({2'b00, ent_b_reg.mlow});
    end

    // threshold test
    logic pass;
    always_comb begin
        pass = (27'(ang_cost_reg) <= 27'(ang_old_reg) + $signed({3'b000, qa})) &&
               (27'(mag_cost_reg) <= 27'(mag_old_reg) + $signed({3'b000, qm}));
    end

    function automatic logic signed [16:0] sat_ang(input logic signed [21:0] v);
        if (v < 22'(gcm_pkg::ANG_MIN)) return 17'(gcm_pkg::ANG_MIN);
        if (v > 22'(gcm_pkg::ANG_MAX)) return 17'(gcm_pkg::ANG_MAX);
        return v[16:0];
    endfunction

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:    if (s_acc) state_next = NWRAP ? S_WRAP : S_DISP;
            S_WRAP:    if (wcnt_reg == 4'd0) state_next = S_DISP;
            S_DISP:    state_next = (req_reg == gcm_pkg::REQ_LOAD) ? S_LOAD : S_FA_RD;
            S_LOAD:    state_next = S_OUT;
            S_FA_RD:   state_next = S_FA_CHK;
            S_FA_CHK: begin
                if (rd_parent != cur_a_reg) state_next = S_FA_RD;
                else if (req_reg == gcm_pkg::REQ_MERGE) state_next = S_FB_RD;
                else state_next = S_OUT;
            end
            S_FB_RD:   state_next = S_FB_CHK;
            S_FB_CHK: begin
                if (rd_parent != cur_b_reg) state_next = S_FB_RD;
                else if (cur_b_reg == r0_reg) state_next = S_OUT;
                else state_next = S_ALIGN;
            end
            S_ALIGN:   state_next = S_SPAN;
            S_SPAN:    state_next = S_DIVW;
            S_DIVW:    if (da_stat.done && dm_stat.done) state_next = S_DECIDE;
            S_DECIDE:  state_next = pass ? S_WR_GONE : S_OUT;
            S_WR_GONE: state_next = S_WR_KEEP;
            S_WR_KEEP: state_next = S_OUT;
            S_OUT:     if (out_free) state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= S_IDLE;
        else          state_reg <= state_next;
    end

    // datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                req_reg  <= s_tuser;
                pa_w_reg <= s_tdata[15:0];
                pb_w_reg <= s_tdata[31:16];
                ang_reg  <= s_tdata[47:32];
                mag_reg  <= s_tdata[63:48];
                wcnt_reg <= 4'd15;
            end
            S_WRAP: begin
                if (32'(pa_w_reg) >= wrap_cmp) pa_w_reg <= pa_w_reg - 16'(wrap_cmp);
                if (32'(pb_w_reg) >= wrap_cmp) pb_w_reg <= pb_w_reg - 16'(wrap_cmp);
                wcnt_reg <= wcnt_reg - 4'd1;
            end
            S_DISP: begin
                cur_a_reg <= IW'(pa_w_reg);
                cur_b_reg <= IW'(pb_w_reg);
            end
            S_LOAD: begin
                res_root_reg   <= cur_a_reg;
                res_count_reg  <= CNT_W'(1);
                res_merge_reg  <= 1'b0;
                res_joined_reg <= 1'b0;
            end
            S_FA_CHK: begin
                if (rd_parent == cur_a_reg) begin
                    r0_reg         <= cur_a_reg;
                    ent_a_reg      <= rd_data;
                    res_root_reg   <= cur_a_reg;
                    res_count_reg  <= rd_data.count;
                    res_merge_reg  <= 1'b0;
                    res_joined_reg <= 1'b0;
                end else begin
                    cur_a_reg <= rd_parent;
                end
            end
            S_FB_CHK: begin
                if (rd_parent == cur_b_reg) begin
                    r1_reg         <= cur_b_reg;
                    ent_b_reg      <= rd_data;
                    res_joined_reg <= cur_b_reg == r0_reg;
                end else begin
                    cur_b_reg <= rd_parent;
                end
            end
            S_ALIGN: begin
                shift_reg <= d[17] ? $signed({1'b0, shift_mag}) : -$signed({1'b0, shift_mag});
                ml01_reg  <= (ent_b_reg.mlow < ent_a_reg.mlow) ? ent_b_reg.mlow : ent_a_reg.mlow;
                mh01_reg  <= (ent_b_reg.mhigh > ent_a_reg.mhigh) ? ent_b_reg.mhigh
                                                                 : ent_a_reg.mhigh;
                sz01_reg  <= SUM_W'(ent_a_reg.count) + SUM_W'(ent_b_reg.count);
            end
            S_SPAN: begin
                tl01_reg     <= tl01;
                th01_reg     <= th01;
                ang_cost_reg <= th01 - tl01;
                ang_old_reg  <= (sp1 < sp0) ? sp1 : sp0;
                mag_cost_reg <= $signed({2'b00, mh01_reg}) - $signed({2'b00, ml01_reg});
                mag_old_reg  <= (mc1 < mc0) ? mc1 : mc0;
            end
            S_DECIDE: begin
                if (pass) begin
                    if (ent_a_reg.count > ent_b_reg.count) begin
                        keep_reg     <= r0_reg;
                        gone_reg     <= r1_reg;
                        gone_ent_reg <= ent_b_reg;
                        res_root_reg <= r0_reg;
                    end else begin
                        keep_reg     <= r1_reg;
                        gone_reg     <= r0_reg;
                        gone_ent_reg <= ent_a_reg;
                        res_root_reg <= r1_reg;
                    end
                    new_ent_reg.count <= sz01_reg[SUM_W-1] ? gcm_pkg::CNT_MAX
                                                           : sz01_reg[CNT_W-1:0];
                    new_ent_reg.alow  <= sat_ang(tl01_reg);
                    new_ent_reg.ahigh <= sat_ang(th01_reg);
                    new_ent_reg.mlow  <= ml01_reg;
                    new_ent_reg.mhigh <= mh01_reg;
                    res_count_reg     <= sz01_reg[SUM_W-1] ? gcm_pkg::CNT_MAX
                                                           : sz01_reg[CNT_W-1:0];
                    res_merge_reg     <= 1'b1;
                end
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (state_reg == S_OUT && out_free) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_OUT && out_free) begin
            m_tdata_reg <= {5'd0, res_joined_reg, res_merge_reg, res_count_reg,
                            16'(res_root_reg)};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // record memory access
    assign load_ent.count = CNT_W'(1);
    assign load_ent.alow  = 17'($signed(ang_reg));
    assign load_ent.ahigh = 17'($signed(ang_reg));
    assign load_ent.mlow  = mag_reg;
    assign load_ent.mhigh = mag_reg;

    assign rd_en     = state_reg == S_FA_RD || state_reg == S_FB_RD;
    assign rd_addr   = (state_reg == S_FB_RD) ? cur_b_reg : cur_a_reg;
    assign wr_en     = state_reg == S_LOAD || state_reg == S_WR_GONE ||
                       state_reg == S_WR_KEEP;
    assign wr_addr   = (state_reg == S_LOAD) ? cur_a_reg :
                       (state_reg == S_WR_GONE) ? gone_reg : keep_reg;
    assign wr_parent = (state_reg == S_LOAD) ? cur_a_reg : keep_reg;
    assign wr_data   = (state_reg == S_LOAD) ? load_ent :
                       (state_reg == S_WR_GONE) ? gone_ent_reg : new_ent_reg;

    gcm_store #(
        .PIXEL_COUNT (PIXEL_COUNT),
        .IW          (IW)
    ) u_store (
        .aclk      (aclk),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_parent (rd_parent),
        .rd_data   (rd_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_parent (wr_parent),
        .wr_data   (wr_data)
    );

    // both allowances divided by the joint size
    assign div_start = state_reg == S_SPAN;

    gcm_div u_div_ang (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (athr_reg),
        .divisor  (sz01_reg),
        .quotient (qa),
        .stat     (da_stat)
    );

    gcm_div u_div_mag (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (mthr_reg),
        .divisor  (sz01_reg),
        .quotient (qm),
        .stat     (dm_stat)
    );

    `GCM_ASSERT_NOW(a_flags_excl, aclk, aresetn, m_tvalid_reg, !(m_tdata_reg[33] && m_tdata_reg[34]), "merge and joined both set")
    `GCM_ASSERT_NOW(a_div_idle, aclk, aresetn, div_start, !da_stat.busy && !dm_stat.busy, "divider restarted while busy")
    `GCM_ASSERT_NOW(a_no_rw, aclk, aresetn, wr_en, !rd_en, "record read and write in one cycle")
    `GCM_ASSERT_NEXT(a_accept_busy, aclk, aresetn, s_acc, !s_tready, "beat taken while item in flight")

endmodule
`default_nettype wire

// ----- tb/gradient_cluster_merge_tb.sv -----
`timescale 1ns / 1ps
`default_nettype none
module gradient_cluster_merge_tb;

    localparam int NPIX       = 65536;
    localparam int IDLE_LIMIT = 20000;

    typedef struct {
        logic [1:0]         kind;
        logic [15:0]        pix_a;
        logic [15:0]        pix_b;
        logic signed [15:0] ang;
        logic [15:0]        mag;
    } cluster_req_t;

    typedef struct {
        logic [15:0] root;
        logic [16:0] members;
        logic        merged;
        logic        joined;
    } cluster_resp_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;   // pixel_a, pixel_b, angle, magnitude
    logic [1:0]  s_tuser = '0;   // req_type
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;        // root_id, set_count, did_merge, already_joined, zero fill
    logic        cfg_wr_en = 1'b0;
    logic        cfg_wr_index = 1'b0;
    logic [gcm_pkg::THR_W-1:0] cfg_wr_data = '0;

    gradient_cluster_merge uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_index(cfg_wr_index), .cfg_wr_data(cfg_wr_data)
    );

    always #5 aclk = ~aclk;

    // shadow copy of the cluster store and thresholds
    logic [15:0]        link_mem  [NPIX];
    logic [16:0]        count_mem [NPIX];
    logic signed [16:0] alow_mem  [NPIX];
    logic signed [16:0] ahigh_mem [NPIX];
    logic [15:0]        mlow_mem  [NPIX];
    logic [15:0]        mhigh_mem [NPIX];
    logic [23:0]        ang_thr = gcm_pkg::ANG_THR_RST;
    logic [23:0]        mag_thr = gcm_pkg::MAG_THR_RST;

    // generator side bookkeeping of loaded pixels
    bit                 loaded [NPIX];
    logic [15:0]        loaded_list [$];

    cluster_req_t  pending_reqs [$];
    cluster_resp_t expected_resps [$];
    cluster_req_t  cur_req;
    int send_idle = 0;
    int recv_stall = 0;
    int errors = 0;
    int idle_cycles = 0;

    function automatic logic [15:0] root_of(logic [15:0] p);
        logic [15:0] cur;
        cur = p;
        for (int i = 0; i < NPIX; i++) begin
            if (link_mem[cur] == cur) break;
            cur = link_mem[cur];
        end
        return cur;
    endfunction

    function automatic longint sat_ang(longint v);
        if (v < gcm_pkg::ANG_MIN) return gcm_pkg::ANG_MIN;
        if (v > gcm_pkg::ANG_MAX) return gcm_pkg::ANG_MAX;
        return v;
    endfunction

    // work out the response to one request and update the shadow store
    function automatic cluster_resp_t cluster_step(cluster_req_t r);
        cluster_resp_t res;
        logic [15:0] r0, r1, keep, gone;
        longint sz0, sz1, sz01, tl0, th0, tl1, th1, ml0, mh0, ml1, mh1;
        longint mean0, mean1, d, ad, q, shift, tl01, th01, ml01, mh01;
        res.merged = 1'b0;
        res.joined = 1'b0;
        if (r.kind == gcm_pkg::REQ_LOAD) begin
            link_mem[r.pix_a]  = r.pix_a;
            count_mem[r.pix_a] = 17'd1;
            alow_mem[r.pix_a]  = r.ang;
            ahigh_mem[r.pix_a] = r.ang;
            mlow_mem[r.pix_a]  = r.mag;
            mhigh_mem[r.pix_a] = r.mag;
            res.root = r.pix_a;
        end else if (r.kind == gcm_pkg::REQ_MERGE) begin
            r0 = root_of(r.pix_a);
            r1 = root_of(r.pix_b);
            res.root = r0;
            if (r0 == r1) begin
                res.joined = 1'b1;
            end else begin
                sz0 = count_mem[r0];
                sz1 = count_mem[r1];
                sz01 = sz0 + sz1;
                if (sz01 == 0) sz01 = 1;
                tl0 = alow_mem[r0]; th0 = ahigh_mem[r0];
                tl1 = alow_mem[r1]; th1 = ahigh_mem[r1];
                ml0 = mlow_mem[r0]; mh0 = mhigh_mem[r0];
                ml1 = mlow_mem[r1]; mh1 = mhigh_mem[r1];
                mean0 = (tl0 + th0) / 2;
                mean1 = (tl1 + th1) / 2;
                d = mean1 - mean0;
                ad = (d < 0) ? -d : d;
                q = (ad + gcm_pkg::PI_Q) / gcm_pkg::TWO_PI;
                shift = (d >= 0) ? -q * gcm_pkg::TWO_PI : q * gcm_pkg::TWO_PI;
                ml01 = (ml0 < ml1) ? ml0 : ml1;
                mh01 = (mh0 > mh1) ? mh0 : mh1;
                tl01 = (tl0 < tl1 + shift) ? tl0 : tl1 + shift;
                th01 = (th0 > th1 + shift) ? th0 : th1 + shift;
                if (th01 - tl01 > gcm_pkg::TWO_PI) th01 = tl01 + gcm_pkg::TWO_PI;
                if (th01 - tl01 <= ((th0 - tl0 < th1 - tl1) ? th0 - tl0 : th1 - tl1)
                                   + longint'(ang_thr) / sz01 &&
                    mh01 - ml01 <= ((mh0 - ml0 < mh1 - ml1) ? mh0 - ml0 : mh1 - ml1)
                                   + longint'(mag_thr) / sz01) begin
                    if (sz0 > sz1) begin
                        keep = r0; gone = r1;
                    end else begin
                        keep = r1; gone = r0;
                    end
                    link_mem[gone] = keep;
                    count_mem[keep] = (sz0 + sz1 > 131071) ? 17'h1FFFF : 17'(sz0 + sz1);
                    alow_mem[keep]  = 17'(sat_ang(tl01));
                    ahigh_mem[keep] = 17'(sat_ang(th01));
                    mlow_mem[keep]  = 16'(ml01);
                    mhigh_mem[keep] = 16'(mh01);
                    res.root = keep;
                    res.merged = 1'b1;
                end
            end
        end else begin
            res.root = root_of(r.pix_a);
        end
        res.members = count_mem[res.root];
        return res;
    endfunction

    // request builders, also tracking which pixels hold data
    task automatic add_req(logic [1:0] k, logic [15:0] a, logic [15:0] b,
                           logic signed [15:0] an, logic [15:0] m);
        cluster_req_t r;
        r.kind = k; r.pix_a = a; r.pix_b = b; r.ang = an; r.mag = m;
        if (k == gcm_pkg::REQ_LOAD && !loaded[a]) begin
            loaded[a] = 1'b1;
            loaded_list.push_back(a);
        end
        pending_reqs.push_back(r);
    endtask

    function automatic logic [15:0] any_loaded();
        return loaded_list[$urandom_range(loaded_list.size() - 1)];
    endfunction

    function automatic logic signed [15:0] rand_angle();
        return 16'($signed($urandom_range(2 * gcm_pkg::PI_Q)) - gcm_pkg::PI_Q);
    endfunction

    // random phase: clustered content on a small pixel pool, with some noise
    task automatic fill_random(int n);
        logic [15:0] pool [24];
        logic signed [15:0] base_ang;
        logic [15:0] base_mag;
        int sel;
        int jit;
        pool[0] = 16'd0;
        pool[1] = 16'hFFFF;
        for (int i = 2; i < 24; i++) pool[i] = 16'($urandom);
        base_ang = rand_angle();
        base_mag = 16'($urandom_range(60000));
        for (int i = 0; i < n; i++) begin
            sel = $urandom_range(99);
            if (i < 12 || sel < 25) begin
                if ($urandom_range(9) == 0)
                    add_req(gcm_pkg::REQ_LOAD, 16'($urandom), 16'($urandom), rand_angle(),
                            16'($urandom));
                else if ($urandom_range(3) == 0)
                    add_req(gcm_pkg::REQ_LOAD, pool[$urandom_range(23)], 16'($urandom),
                            rand_angle(), 16'($urandom));
                else begin
                    // angle jittered around the cluster centre, kept within +-pi
                    jit = int'(base_ang) + int'($urandom_range(4000)) - 2000;
                    if (jit > gcm_pkg::PI_Q) jit = gcm_pkg::PI_Q;
                    if (jit < -gcm_pkg::PI_Q) jit = -gcm_pkg::PI_Q;
                    add_req(gcm_pkg::REQ_LOAD, pool[$urandom_range(23)], 16'($urandom),
                            16'(jit), base_mag + 16'($urandom_range(400)));
                end
            end else if (sel < 75) begin
                add_req(gcm_pkg::REQ_MERGE, any_loaded(), any_loaded(), rand_angle(),
                        16'($urandom));
            end else begin
                add_req(($urandom_range(3) == 0) ? gcm_pkg::REQ_ALT : gcm_pkg::REQ_QUERY,
                        any_loaded(), 16'($urandom), rand_angle(), 16'($urandom));
            end
        end
    endtask

    task automatic drain();
        while (pending_reqs.size() != 0 || s_tvalid || expected_resps.size() != 0)
            @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    task automatic write_cfg(logic idx, logic [23:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data <= val;
        if (idx == gcm_pkg::CFG_ANGLE_THR) ang_thr = val;
        else mag_thr = val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // driver: present beats from the pending queue, predicting on acceptance
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                expected_resps.push_back(cluster_step(cur_req));
            if (!s_tvalid || s_tready) begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle) begin
                    cur_req = pending_reqs.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser <= cur_req.kind;
                    s_tdata <= {cur_req.mag, cur_req.ang, cur_req.pix_b, cur_req.pix_a};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each result beat with the oldest expectation
    always @(posedge aclk) begin
        cluster_resp_t e;
        if (aresetn) begin
            m_tready <= ($urandom_range(99) >= recv_stall);
            if (m_tvalid && m_tready) begin
                if (expected_resps.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("unexpected result beat %h", m_tdata);
                end else begin
                    e = expected_resps.pop_front();
                    if (m_tdata[15:0] !== e.root || m_tdata[32:16] !== e.members ||
                        m_tdata[33] !== e.merged || m_tdata[34] !== e.joined) begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: exp root %0d count %0d merged %b joined %b, got root %0d count %0d merged %b joined %b",
                                     e.root, e.members, e.merged, e.joined, m_tdata[15:0],
                                     m_tdata[32:16], m_tdata[33], m_tdata[34]);
                    end
                end
            end
        end
    end

    // watchdog on cycles with work outstanding but no beat moving
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (pending_reqs.size() == 0 && !s_tvalid && expected_resps.size() == 0))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: extremes, wrap shift, rejection, ties, repeats, reload
        add_req(gcm_pkg::REQ_LOAD, 16'd0, 16'hFFFF, -16'sd25736, 16'd0);
        add_req(gcm_pkg::REQ_LOAD, 16'hFFFF, 16'd0, 16'sd25736, 16'hFFFF);
        add_req(gcm_pkg::REQ_MERGE, 16'd0, 16'hFFFF, 16'sd0, 16'd0);
        add_req(gcm_pkg::REQ_LOAD, 16'd1, 16'd0, 16'sd25000, 16'd100);
        add_req(gcm_pkg::REQ_LOAD, 16'd2, 16'd0, -16'sd25000, 16'd120);
        add_req(gcm_pkg::REQ_MERGE, 16'd1, 16'd2, 16'sd0, 16'd0);
        add_req(gcm_pkg::REQ_MERGE, 16'd2, 16'd1, 16'sd0, 16'd0);
        add_req(gcm_pkg::REQ_QUERY, 16'd2, 16'd0, 16'sd0, 16'd0);
        add_req(gcm_pkg::REQ_ALT, 16'd1, 16'd0, 16'sd0, 16'd0);
        add_req(gcm_pkg::REQ_LOAD, 16'd3, 16'd0, 16'sd24000, 16'd110);
        add_req(gcm_pkg::REQ_MERGE, 16'd3, 16'd1, 16'sd0, 16'd0);
        add_req(gcm_pkg::REQ_LOAD, 16'd4, 16'd0, 16'sd100, 16'd500);
        add_req(gcm_pkg::REQ_LOAD, 16'd5, 16'd0, 16'sd120, 16'd510);
        add_req(gcm_pkg::REQ_MERGE, 16'd4, 16'd5, 16'sd0, 16'd0);
        add_req(gcm_pkg::REQ_MERGE, 16'd5, 16'd3, 16'sd0, 16'd0);
        add_req(gcm_pkg::REQ_LOAD, 16'd2, 16'd0, 16'sd0, 16'd120);
        add_req(gcm_pkg::REQ_QUERY, 16'd1, 16'd0, 16'sd0, 16'd0);
        add_req(gcm_pkg::REQ_QUERY, 16'd2, 16'd0, 16'sd0, 16'd0);
        add_req(gcm_pkg::REQ_QUERY, 16'hFFFF, 16'd0, 16'sd0, 16'd0);
        drain();

        // random phases over threshold settings and idling patterns
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    send_idle = 0;  recv_stall = 0;
                end
                1: begin
                    send_idle = 57; recv_stall = 0;
                    write_cfg(gcm_pkg::CFG_ANGLE_THR, 24'd0);
                    write_cfg(gcm_pkg::CFG_MAG_THR, 24'd0);
                end
                2: begin
                    send_idle = 0;  recv_stall = 57;
                    write_cfg(gcm_pkg::CFG_ANGLE_THR, 24'hFFFFFF);
                    write_cfg(gcm_pkg::CFG_MAG_THR, 24'hFFFFFF);
                end
                default: begin
                    send_idle = 23; recv_stall = 23;
                    write_cfg(gcm_pkg::CFG_ANGLE_THR, 24'($urandom_range(2000000)));
                    write_cfg(gcm_pkg::CFG_MAG_THR, 24'($urandom_range(20000)));
                end
            endcase
            fill_random(460);
            drain();
        end

        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
`default_nettype wire

// ----- gradient_cluster_merge.f -----
+incdir+src
src/gcm_pkg.sv
src/gcm_store.sv
src/gcm_div.sv
src/gradient_cluster_merge.sv
tb/gradient_cluster_merge_tb.sv
